/* design/bpbp_pkg.sv */
// Package for the bundle primary and block parser.
// Holds the parse positions, field kinds, status codes and the result word type.
// No dependencies.
package bpbp_pkg;

    // Default width of the SDNV value accumulator
    localparam int VALUE_BITS_DEF = 32;

    localparam logic [7:0] VERSION_BYTE = 8'h06;

    // Parse position within the bundle
    typedef enum logic [4:0] {
        POS_VERSION   = 5'd0,
        POS_FLAGS     = 5'd1,
        POS_PLEN      = 5'd2,
        POS_DST_NODE  = 5'd3,
        POS_DST_SRV   = 5'd4,
        POS_SRC_NODE  = 5'd5,
        POS_SRC_SRV   = 5'd6,
        POS_RPT_NODE  = 5'd7,
        POS_RPT_SRV   = 5'd8,
        POS_CUST_NODE = 5'd9,
        POS_CUST_SRV  = 5'd10,
        POS_TIME      = 5'd11,
        POS_SEQ       = 5'd12,
        POS_LIFE      = 5'd13,
        POS_DICT      = 5'd14,
        POS_FRAG_OFF  = 5'd15,
        POS_ADU_LEN   = 5'd16,
        POS_BTYPE     = 5'd17,
        POS_BFLAGS    = 5'd18,
        POS_BLEN      = 5'd19,
        POS_PAYLOAD   = 5'd20,
        POS_SINK      = 5'd21
    } pos_t;

    // Field kinds (primary fields use position minus one)
    localparam logic [4:0] KIND_BLK_TYPE  = 5'd16;
    localparam logic [4:0] KIND_BLK_FLAGS = 5'd17;
    localparam logic [4:0] KIND_BLK_LEN   = 5'd18;
    localparam logic [4:0] KIND_PAYLOAD   = 5'd19;
    localparam logic [4:0] KIND_STATUS    = 5'd20;

    // Parse status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_VER    = 3'd1;
    localparam logic [2:0] ST_DICT_NZ    = 3'd2;
    localparam logic [2:0] ST_LEN_MISM   = 3'd3;
    localparam logic [2:0] ST_TRUNCATED  = 3'd4;
    localparam logic [2:0] ST_SDNV_OVF   = 3'd5;

    // One result word
    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] value;
        logic [7:0]  block;
        logic [2:0]  status;
        logic        done;
    } result_t;

endpackage

/* design/bundle_primary_and_block_parser_top.sv */
// Top level of the bundle primary and block parser.
// Uses bpbp_pkg for positions, kinds, status codes and the result word.

// Parses a serialized bundle at one byte per clock. Each accepted byte updates the
// parse state in the same cycle and, when it completes a field, writes one result
// word into the output register. A second result register catches a word while the
// output is stalled; in_stall rises only when both are full, so bytes flow at one
// per cycle whenever the consumer keeps up. The byte marked last always yields one
// word with bundle_done set and returns the parser to its reset state. After an error
// the parser drops bytes silently until the last byte, which reports the latched status.
module bundle_primary_and_block_parser_top #(
    parameter int VALUE_BITS = bpbp_pkg::VALUE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  field_kind,
    output logic [31:0] field_value,
    output logic [7:0]  block_number,
    output logic [2:0]  parse_status,
    output logic        bundle_done
);

    localparam int CMP_W = (VALUE_BITS > 32) ? VALUE_BITS : 32;

    // Parse state
    bpbp_pkg::pos_t          pos_reg, pos_next, pos_step;
    logic [VALUE_BITS-1:0]   acc_reg, acc_next;
    logic                    ovf_reg, ovf_next;
    logic [31:0]             cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0]   plen_reg, plen_next;
    logic                    frag_reg, frag_next;
    logic [VALUE_BITS-1:0]   rem_reg, rem_next;
    logic [7:0]              blk_reg, blk_next;
    logic                    err_reg, err_next, err_step;
    logic [2:0]              code_reg, code_next, code_step;

    // Output buffer
    bpbp_pkg::result_t       out_reg, out_next, skid_reg, skid_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    skid_valid_reg, skid_valid_next;

    // Step decode
    logic                    accept;
    logic                    sdnv_done;
    logic                    ovf_bit;
    logic [VALUE_BITS-1:0]   acc_new;
    logic                    v_ovf;
    logic [31:0]             cnt_inc;
    logic                    len_match;
    logic [VALUE_BITS-1:0]   rem_dec;
    logic [7:0]              blk_inc;

    // Result of this byte
    logic                    emit;
    logic [4:0]              res_kind;
    logic [CMP_W-1:0]        res_val;
    logic [2:0]              res_status;
    logic                    res_valid;
    bpbp_pkg::result_t       res;

    assign accept   = in_valid && !in_stall;
    assign in_stall = skid_valid_reg;

    // Decode one SDNV byte and the shared counters
    always_comb
    begin
        ovf_bit   = (acc_reg[VALUE_BITS-1:VALUE_BITS-7] != 7'd0);
        acc_new   = {acc_reg[VALUE_BITS-8:0], in_byte[6:0]};
        sdnv_done = !in_byte[7];
        v_ovf     = ovf_reg || ovf_bit;
        cnt_inc   = ((pos_reg >= bpbp_pkg::POS_DST_NODE) && (cnt_reg != '1))
                    ? cnt_reg + 32'd1 : cnt_reg;
        len_match = (CMP_W'(cnt_inc) == CMP_W'(plen_reg));
        rem_dec   = (rem_reg != '0) ? rem_reg - VALUE_BITS'(1) : rem_reg;
        blk_inc   = (blk_reg != 8'hFF) ? blk_reg + 8'd1 : blk_reg;
    end

    // Next parse state
    always_comb
    begin
        pos_step  = pos_reg;
        acc_next  = acc_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        plen_next = plen_reg;
        frag_next = frag_reg;
        rem_next  = rem_reg;
        blk_next  = blk_reg;
        err_step  = err_reg;
        code_step = code_reg;

        unique case (pos_reg)
            bpbp_pkg::POS_VERSION:
            begin
                if (in_byte != bpbp_pkg::VERSION_BYTE)
                begin
                    err_step  = 1'b1;
                    code_step = bpbp_pkg::ST_BAD_VER;
                    pos_step  = bpbp_pkg::POS_SINK;
                end
                else
                begin
                    pos_step = bpbp_pkg::POS_FLAGS;
                end
            end
            bpbp_pkg::POS_FLAGS, bpbp_pkg::POS_PLEN, bpbp_pkg::POS_DST_NODE,
            bpbp_pkg::POS_DST_SRV, bpbp_pkg::POS_SRC_NODE, bpbp_pkg::POS_SRC_SRV,
            bpbp_pkg::POS_RPT_NODE, bpbp_pkg::POS_RPT_SRV, bpbp_pkg::POS_CUST_NODE,
            bpbp_pkg::POS_CUST_SRV, bpbp_pkg::POS_TIME, bpbp_pkg::POS_SEQ,
            bpbp_pkg::POS_LIFE, bpbp_pkg::POS_DICT, bpbp_pkg::POS_FRAG_OFF,
            bpbp_pkg::POS_ADU_LEN:
            begin
                cnt_next = cnt_inc;
                acc_next = acc_new;
                ovf_next = v_ovf;
                if (sdnv_done)
                begin
                    acc_next = '0;
                    ovf_next = 1'b0;
                    if (v_ovf)
                    begin
                        err_step  = 1'b1;
                        code_step = bpbp_pkg::ST_SDNV_OVF;
                        pos_step  = bpbp_pkg::POS_SINK;
                    end
                    else if (pos_reg == bpbp_pkg::POS_FLAGS)
                    begin
                        frag_next = acc_new[0];
                        pos_step  = bpbp_pkg::POS_PLEN;
                    end
                    else if (pos_reg == bpbp_pkg::POS_PLEN)
                    begin
                        plen_next = acc_new;
                        cnt_next  = '0;
                        pos_step  = bpbp_pkg::POS_DST_NODE;
                    end
                    else if (pos_reg == bpbp_pkg::POS_DICT && acc_new != '0)
                    begin
                        err_step  = 1'b1;
                        code_step = bpbp_pkg::ST_DICT_NZ;
                        pos_step  = bpbp_pkg::POS_SINK;
                    end
                    else if ((pos_reg == bpbp_pkg::POS_DICT && !frag_reg) ||
                             pos_reg == bpbp_pkg::POS_ADU_LEN)
                    begin
                        if (!len_match)
                        begin
                            err_step  = 1'b1;
                            code_step = bpbp_pkg::ST_LEN_MISM;
                            pos_step  = bpbp_pkg::POS_SINK;
                        end
                        else
                        begin
                            pos_step = bpbp_pkg::POS_BTYPE;
                        end
                    end
                    else
                    begin
                        pos_step = bpbp_pkg::pos_t'(pos_reg + 5'd1);
                    end
                end
            end
            bpbp_pkg::POS_BTYPE:
            begin
                if (!in_last)
                begin
                    acc_next = '0;
                    ovf_next = 1'b0;
                    pos_step = bpbp_pkg::POS_BFLAGS;
                end
            end
            bpbp_pkg::POS_BFLAGS, bpbp_pkg::POS_BLEN:
            begin
                acc_next = acc_new;
                ovf_next = v_ovf;
                if (sdnv_done)
                begin
                    acc_next = '0;
                    ovf_next = 1'b0;
                    if (v_ovf)
                    begin
                        err_step  = 1'b1;
                        code_step = bpbp_pkg::ST_SDNV_OVF;
                        pos_step  = bpbp_pkg::POS_SINK;
                    end
                    else if (pos_reg == bpbp_pkg::POS_BFLAGS)
                    begin
                        pos_step = bpbp_pkg::POS_BLEN;
                    end
                    else if (acc_new == '0)
                    begin
                        blk_next = blk_inc;
                        pos_step = bpbp_pkg::POS_BTYPE;
                    end
                    else
                    begin
                        rem_next = acc_new;
                        pos_step = bpbp_pkg::POS_PAYLOAD;
                    end
                end
            end
            bpbp_pkg::POS_PAYLOAD:
            begin
                rem_next = rem_dec;
                if (rem_dec == '0)
                begin
                    blk_next = blk_inc;
                    pos_step = bpbp_pkg::POS_BTYPE;
                end
            end
            default:
            begin
                // sink: drop bytes until the last one
            end
        endcase

        pos_next  = pos_step;
        err_next  = err_step;
        code_next = code_step;

        // Return to reset state after the final byte
        if (in_last)
        begin
            pos_next  = bpbp_pkg::POS_VERSION;
            acc_next  = '0;
            ovf_next  = 1'b0;
            cnt_next  = '0;
            plen_next = '0;
            frag_next = 1'b0;
            rem_next  = '0;
            blk_next  = '0;
            err_next  = 1'b0;
            code_next = bpbp_pkg::ST_OK;
        end
    end

    // Result word for this byte
    always_comb
    begin
        emit     = 1'b0;
        res_kind = bpbp_pkg::KIND_STATUS;
        res_val  = '0;

        unique case (pos_reg)
            bpbp_pkg::POS_VERSION:
            begin
                if (in_byte != bpbp_pkg::VERSION_BYTE)
                begin
                    emit    = 1'b1;
                    res_val = CMP_W'(in_byte);
                end
            end
            bpbp_pkg::POS_FLAGS, bpbp_pkg::POS_PLEN, bpbp_pkg::POS_DST_NODE,
            bpbp_pkg::POS_DST_SRV, bpbp_pkg::POS_SRC_NODE, bpbp_pkg::POS_SRC_SRV,
            bpbp_pkg::POS_RPT_NODE, bpbp_pkg::POS_RPT_SRV, bpbp_pkg::POS_CUST_NODE,
            bpbp_pkg::POS_CUST_SRV, bpbp_pkg::POS_TIME, bpbp_pkg::POS_SEQ,
            bpbp_pkg::POS_LIFE, bpbp_pkg::POS_DICT, bpbp_pkg::POS_FRAG_OFF,
            bpbp_pkg::POS_ADU_LEN:
            begin
                if (sdnv_done)
                begin
                    emit     = 1'b1;
                    res_kind = pos_reg - 5'd1;
                    res_val  = CMP_W'(acc_new);
                end
            end
            bpbp_pkg::POS_BTYPE:
            begin
                if (!in_last)
                begin
                    emit     = 1'b1;
                    res_kind = bpbp_pkg::KIND_BLK_TYPE;
                    res_val  = CMP_W'(in_byte);
                end
            end
            bpbp_pkg::POS_BFLAGS, bpbp_pkg::POS_BLEN:
            begin
                if (sdnv_done)
                begin
                    emit     = 1'b1;
                    res_kind = (pos_reg == bpbp_pkg::POS_BFLAGS)
                               ? bpbp_pkg::KIND_BLK_FLAGS : bpbp_pkg::KIND_BLK_LEN;
                    res_val  = CMP_W'(acc_new);
                end
            end
            bpbp_pkg::POS_PAYLOAD:
            begin
                emit     = 1'b1;
                res_kind = bpbp_pkg::KIND_PAYLOAD;
                res_val  = CMP_W'(in_byte);
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        // Latched error wins; a final byte outside a block boundary is truncation
        if (err_step)
            res_status = code_step;
        else if (in_last && pos_step != bpbp_pkg::POS_BTYPE)
            res_status = bpbp_pkg::ST_TRUNCATED;
        else
            res_status = bpbp_pkg::ST_OK;

        res_valid  = accept && (emit || in_last);
        res.kind   = res_kind;
        res.value  = res_val[31:0];
        res.block  = blk_reg;
        res.status = res_status;
        res.done   = in_last;
    end

    // Output register with a skid word behind it
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = res;
                out_valid_next = res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    // Hold parse control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= bpbp_pkg::POS_VERSION;
            acc_reg        <= '0;
            ovf_reg        <= 1'b0;
            cnt_reg        <= '0;
            plen_reg       <= '0;
            frag_reg       <= 1'b0;
            rem_reg        <= '0;
            blk_reg        <= '0;
            err_reg        <= 1'b0;
            code_reg       <= bpbp_pkg::ST_OK;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pos_reg  <= pos_next;
                acc_reg  <= acc_next;
                ovf_reg  <= ovf_next;
                cnt_reg  <= cnt_next;
                plen_reg <= plen_next;
                frag_reg <= frag_next;
                rem_reg  <= rem_next;
                blk_reg  <= blk_next;
                err_reg  <= err_next;
                code_reg <= code_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result words carry no reset
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid    = out_valid_reg;
    assign field_kind   = out_reg.kind;
    assign field_value  = out_reg.value;
    assign block_number = out_reg.block;
    assign parse_status = out_reg.status;
    assign bundle_done  = out_reg.done;

    // The skid word only fills behind a held output word
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word valid without output word");

    // A final byte always returns the parser to the version byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_last) |=> (pos_reg == bpbp_pkg::POS_VERSION))
        else $error("parser not reset after final byte");

    // A latched error parks the parser in the sink
    assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> (pos_reg == bpbp_pkg::POS_SINK))
        else $error("error latched outside sink");

    // No extension block is counted before the version byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == bpbp_pkg::POS_VERSION) |-> (blk_reg == 8'd0))
        else $error("block counter nonzero at bundle start");

    // A final byte always produces a word, so an accepted final byte fills a slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_last) |=> out_valid_reg)
        else $error("final byte yielded no result");

endmodule

/* sim/testbench.sv */
// Testbench for bundle_primary_and_block_parser_top: feeds whole bundles a byte at a time
// and checks every field word against a cycle-free model of the parser.
// Depends on bpbp_pkg and the parser top level.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VB = bpbp_pkg::VALUE_BITS_DEF;
    localparam logic [63:0] VMASK = {64{1'b1}} >> (64 - VB);

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } link_byte_t;

    typedef enum int {
        SHAPE_GOOD,
        SHAPE_BAD_VER,
        SHAPE_DICT,
        SHAPE_PLEN,
        SHAPE_OVF,
        SHAPE_NOISE
    } bundle_shape_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  in_byte = 8'h00;
    logic        in_last = 1'b0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [4:0]  field_kind;
    logic [31:0] field_value;
    logic [7:0]  block_number;
    logic [2:0]  parse_status;
    logic        bundle_done;

    link_byte_t          pending_bytes[$];
    logic [7:0]          bundle_bytes[$];
    bpbp_pkg::result_t   expected_words[$];
    link_byte_t          nxt;
    int                  gap_left = 0;
    int                  stall_left = 0;
    bit                  in_burst = 1'b0;
    bit                  out_burst = 1'b0;
    int                  mismatches = 0;

    // Parser model state
    bpbp_pkg::pos_t      at_pos;
    logic [63:0]         acc;
    bit                  acc_ovf;
    logic [31:0]         prim_cnt;
    logic [63:0]         prim_len;
    bit                  frag;
    logic [63:0]         pay_left;
    logic [7:0]          blk_cnt;
    bit                  err;
    logic [2:0]          err_code;

    bundle_primary_and_block_parser_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .field_kind   (field_kind),
        .field_value  (field_value),
        .block_number (block_number),
        .parse_status (parse_status),
        .bundle_done  (bundle_done)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_parser();
        at_pos   = bpbp_pkg::POS_VERSION;
        acc      = '0;
        acc_ovf  = 1'b0;
        prim_cnt = '0;
        prim_len = '0;
        frag     = 1'b0;
        pay_left = '0;
        blk_cnt  = '0;
        err      = 1'b0;
        err_code = bpbp_pkg::ST_OK;
    endfunction

    function automatic void hold_error(input logic [2:0] code);
        err      = 1'b1;
        err_code = code;
        at_pos   = bpbp_pkg::POS_SINK;
    endfunction

    function automatic void close_block();
        if (blk_cnt != 8'hFF)
            blk_cnt++;
        at_pos = bpbp_pkg::POS_BTYPE;
    endfunction

    // Shift one SDNV byte in; true when the field ends
    function automatic bit sdnv_step(input logic [7:0] b);
        if ((acc >> (VB - 7)) != 0)
            acc_ovf = 1'b1;
        acc = ((acc << 7) | {57'd0, b[6:0]}) & VMASK;
        return !b[7];
    endfunction

    // Advance the parser model by one byte and queue the field word it yields
    function automatic void parse_byte(input logic [7:0] b, input logic fin);
        bpbp_pkg::pos_t    p;
        logic [7:0]        bn;
        bit                emit;
        bit                ovf;
        logic [4:0]        kind;
        logic [63:0]       val;
        logic [63:0]       v;
        logic [2:0]        st;
        bpbp_pkg::result_t w;
        p    = at_pos;
        bn   = blk_cnt;
        emit = 1'b0;
        kind = bpbp_pkg::KIND_STATUS;
        val  = '0;
        if (p == bpbp_pkg::POS_VERSION)
        begin
            if (b != bpbp_pkg::VERSION_BYTE)
            begin
                emit = 1'b1;
                val  = {56'd0, b};
                hold_error(bpbp_pkg::ST_BAD_VER);
            end
            else
                at_pos = bpbp_pkg::POS_FLAGS;
        end
        else if (p <= bpbp_pkg::POS_ADU_LEN)
        begin
            if (p >= bpbp_pkg::POS_DST_NODE && prim_cnt != 32'hFFFF_FFFF)
                prim_cnt++;
            if (sdnv_step(b))
            begin
                v       = acc;
                ovf     = acc_ovf;
                acc     = '0;
                acc_ovf = 1'b0;
                emit    = 1'b1;
                kind    = p - 5'd1;
                val     = v;
                if (ovf)
                    hold_error(bpbp_pkg::ST_SDNV_OVF);
                else if (p == bpbp_pkg::POS_FLAGS)
                begin
                    frag   = v[0];
                    at_pos = bpbp_pkg::POS_PLEN;
                end
                else if (p == bpbp_pkg::POS_PLEN)
                begin
                    prim_len = v;
                    prim_cnt = '0;
                    at_pos   = bpbp_pkg::POS_DST_NODE;
                end
                else if (p == bpbp_pkg::POS_DICT && v != 0)
                    hold_error(bpbp_pkg::ST_DICT_NZ);
                else if ((p == bpbp_pkg::POS_DICT && !frag) || p == bpbp_pkg::POS_ADU_LEN)
                begin
                    if ({32'd0, prim_cnt} != prim_len)
                        hold_error(bpbp_pkg::ST_LEN_MISM);
                    else
                        at_pos = bpbp_pkg::POS_BTYPE;
                end
                else
                    at_pos = bpbp_pkg::pos_t'(p + 5'd1);
            end
        end
        else if (p == bpbp_pkg::POS_BTYPE)
        begin
            // a trailing byte where a block type is due is dropped
            if (!fin)
            begin
                emit    = 1'b1;
                kind    = bpbp_pkg::KIND_BLK_TYPE;
                val     = {56'd0, b};
                acc     = '0;
                acc_ovf = 1'b0;
                at_pos  = bpbp_pkg::POS_BFLAGS;
            end
        end
        else if (p == bpbp_pkg::POS_BFLAGS || p == bpbp_pkg::POS_BLEN)
        begin
            if (sdnv_step(b))
            begin
                v       = acc;
                ovf     = acc_ovf;
                acc     = '0;
                acc_ovf = 1'b0;
                emit    = 1'b1;
                kind    = (p == bpbp_pkg::POS_BFLAGS) ? bpbp_pkg::KIND_BLK_FLAGS
                                                      : bpbp_pkg::KIND_BLK_LEN;
                val     = v;
                if (ovf)
                    hold_error(bpbp_pkg::ST_SDNV_OVF);
                else if (p == bpbp_pkg::POS_BFLAGS)
                    at_pos = bpbp_pkg::POS_BLEN;
                else if (v == 0)
                    close_block();
                else
                begin
                    pay_left = v;
                    at_pos   = bpbp_pkg::POS_PAYLOAD;
                end
            end
        end
        else if (p == bpbp_pkg::POS_PAYLOAD)
        begin
            emit = 1'b1;
            kind = bpbp_pkg::KIND_PAYLOAD;
            val  = {56'd0, b};
            if (pay_left != 0)
                pay_left--;
            if (pay_left == 0)
                close_block();
        end

        // Last byte always reports: latched error, clean end, or truncation
        if (fin)
        begin
            if (err)
                st = err_code;
            else if (at_pos == bpbp_pkg::POS_BTYPE)
                st = bpbp_pkg::ST_OK;
            else
                st = bpbp_pkg::ST_TRUNCATED;
        end
        else
            st = err ? err_code : bpbp_pkg::ST_OK;

        if (emit || fin)
        begin
            w.kind   = kind;
            w.value  = val[31:0];
            w.block  = bn;
            w.status = st;
            w.done   = fin;
            expected_words.push_back(w);
        end
        if (fin)
            clear_parser();
    endfunction

    function automatic int draw_idle(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return 64'd0;
            1, 2, 3: return 64'($urandom_range(1, 127));
            4, 5:    return 64'($urandom_range(128, 16383));
            6, 7:    return 64'($urandom);
            8:       return 64'hFFFF_FFFF;
            default: return 64'($urandom_range(0, 2097151));
        endcase
    endfunction

    // Value too wide for the accumulator
    function automatic logic [63:0] wide_value();
        return {16'd0, 16'($urandom_range(1, 65535)), 32'($urandom)};
    endfunction

    function automatic int sdnv_len(input logic [63:0] v, input int pad);
        int n;
        n = 1;
        while (n < 10 && (v >> (7 * n)) != 0)
            n++;
        return n + pad;
    endfunction

    // Append an SDNV, optionally with redundant leading zero groups
    task automatic push_sdnv(input logic [63:0] v, input int pad);
        int n;
        n = sdnv_len(v, 0);
        repeat (pad)
            bundle_bytes.push_back(8'h80);
        for (int i = n - 1; i >= 0; i--)
            bundle_bytes.push_back({i != 0, 7'(v >> (7 * i))});
    endtask

    task automatic add_byte(input logic [7:0] b, input logic fin);
        link_byte_t t;
        t.data = b;
        t.fin  = fin;
        pending_bytes.push_back(t);
    endtask

    task automatic build_bundle(input bundle_shape_t shape, input int nblk,
                                input bit empty_only);
        logic [63:0] fv[14];
        int          pad[14];
        int          nf;
        int          body_len;
        int          k;
        int          r;
        int          blen;
        int          cut;
        logic [63:0] flags;
        logic [63:0] plen;
        logic [7:0]  vb;
        bit          fr;
        bit          cut_short;
        bundle_bytes.delete();
        cut_short = 1'b0;
        if (shape == SHAPE_NOISE)
        begin
            bundle_bytes.push_back($urandom_range(0, 1) ? bpbp_pkg::VERSION_BYTE
                                                        : 8'($urandom));
            repeat ($urandom_range(1, 12))
                bundle_bytes.push_back(8'($urandom));
        end
        else
        begin
            fr       = $urandom_range(0, 1);
            nf       = fr ? 14 : 12;
            flags    = rand_value();
            flags[0] = fr;
            for (int i = 0; i < nf; i++)
            begin
                fv[i]  = rand_value();
                pad[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
            end
            // dictionary length sits at index 11
            fv[11] = (shape == SHAPE_DICT) ? 64'($urandom_range(1, 300)) : 64'd0;
            if (shape == SHAPE_OVF)
            begin
                k = $urandom_range(0, nf);
                if (k == nf)
                    flags = wide_value();
                else
                    fv[k] = wide_value();
            end
            body_len = 0;
            for (int i = 0; i < nf; i++)
                body_len += sdnv_len(fv[i], pad[i]);
            plen = 64'(body_len);
            if (shape == SHAPE_PLEN)
                plen = $urandom_range(0, 1) ? plen + 1 : plen - 1;

            vb = 8'($urandom);
            if (vb == bpbp_pkg::VERSION_BYTE)
                vb = vb + 8'd1;
            bundle_bytes.push_back(shape == SHAPE_BAD_VER ? vb : bpbp_pkg::VERSION_BYTE);
            push_sdnv(flags, 0);
            push_sdnv(plen, 0);
            for (int i = 0; i < nf; i++)
                push_sdnv(fv[i], pad[i]);

            // Extension blocks; in empty-only mode each is three bytes
            for (int bi = 0; bi < nblk && !cut_short; bi++)
            begin
                bundle_bytes.push_back(8'($urandom));
                push_sdnv(empty_only ? 64'd0 : rand_value(),
                          (!empty_only && $urandom_range(0, 15) == 0) ? 1 : 0);
                r = $urandom_range(0, 99);
                if (empty_only || r < 20)
                    blen = 0;
                else if (r < 95)
                    blen = $urandom_range(1, 6);
                else if (r < 98)
                    blen = $urandom_range(20, 80);
                else
                    blen = -1;
                if (blen < 0)
                begin
                    // declared length far beyond what follows
                    push_sdnv(64'($urandom) | 64'h8000, 0);
                    repeat ($urandom_range(0, 4))
                        bundle_bytes.push_back(8'($urandom));
                    cut_short = 1'b1;
                end
                else
                begin
                    push_sdnv(64'(blen), 0);
                    repeat (blen)
                        bundle_bytes.push_back(8'($urandom));
                end
            end

            // End exactly, with a trailing byte, or cut short
            r = empty_only ? 6 : $urandom_range(0, 9);
            if (r == 6 || r == 7)
                bundle_bytes.push_back(8'($urandom));
            else if (r >= 8 && !cut_short)
            begin
                cut = $urandom_range(1, bundle_bytes.size());
                while (bundle_bytes.size() > cut)
                    void'(bundle_bytes.pop_back());
            end
        end
        foreach (bundle_bytes[i])
            add_byte(bundle_bytes[i], i == bundle_bytes.size() - 1);
    endtask

    // Compare one accepted word with the oldest expectation
    task automatic check_word();
        bpbp_pkg::result_t want;
        if (expected_words.size() == 0)
        begin
            $display("%0t: unexpected word kind %0d value %0h", $realtime, field_kind,
                     field_value);
            mismatches++;
        end
        else
        begin
            want = expected_words.pop_front();
            if (field_kind !== want.kind)
            begin
                $display("%0t: field_kind expected %0d actual %0d", $realtime,
                         want.kind, field_kind);
                mismatches++;
            end
            if (field_value !== want.value)
            begin
                $display("%0t: field_value expected %0h actual %0h", $realtime,
                         want.value, field_value);
                mismatches++;
            end
            if (block_number !== want.block)
            begin
                $display("%0t: block_number expected %0d actual %0d", $realtime,
                         want.block, block_number);
                mismatches++;
            end
            if (parse_status !== want.status)
            begin
                $display("%0t: parse_status expected %0d actual %0d", $realtime,
                         want.status, parse_status);
                mismatches++;
            end
            if (bundle_done !== want.done)
            begin
                $display("%0t: bundle_done expected %0b actual %0b", $realtime,
                         want.done, bundle_done);
                mismatches++;
            end
        end
    endtask

    // Byte driver: hold a stalled word, otherwise advance or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte  <= 8'h00;
            in_last  <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                parse_byte(in_byte, in_last);
            if (!in_valid || !in_stall)
            begin
                if ($urandom_range(0, 199) == 0)
                    in_burst = !in_burst;
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    nxt = pending_bytes.pop_front();
                    in_byte  <= nxt.data;
                    in_last  <= nxt.fin;
                    in_valid <= 1'b1;
                    gap_left = draw_idle(in_burst);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: check each taken word, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_word();
            if ($urandom_range(0, 199) == 0)
                out_burst = !out_burst;
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = draw_idle(out_burst);
                out_stall <= 1'b0;
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int            sent;
        int            r;
        bundle_shape_t shape;
        clear_parser();

        // bad version on a lone last byte
        add_byte(8'hFF, 1'b1);
        // flags field too wide for the accumulator
        add_byte(bpbp_pkg::VERSION_BYTE, 1'b0);
        add_byte(8'h90, 1'b0);
        repeat (3)
            add_byte(8'h80, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b1);
        // smallest clean bundle, then a trailing byte
        add_byte(bpbp_pkg::VERSION_BYTE, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'd12, 1'b0);
        repeat (12)
            add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b1);

        // Random bundles, mostly well formed; one drives the block counter to saturate at 255
        sent = 0;
        for (int n = 0; sent < 900; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                shape = SHAPE_GOOD;
            else if (r < 68)
                shape = SHAPE_BAD_VER;
            else if (r < 76)
                shape = SHAPE_DICT;
            else if (r < 84)
                shape = SHAPE_PLEN;
            else if (r < 92)
                shape = SHAPE_OVF;
            else
                shape = SHAPE_NOISE;
            if (n == 3)
                build_bundle(SHAPE_GOOD, 260, 1'b1);
            else
                build_bundle(shape, (shape == SHAPE_GOOD) ? $urandom_range(0, 3) : 1, 1'b0);
            sent += bundle_bytes.size();
        end

        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Sample between edges so every accepted byte and checked word is settled
        while (pending_bytes.size() != 0 || in_valid)
            @(negedge clk);
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (10)
            @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Hard limit on run time
    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
